/* src/gbte_pkg.sv */
// package: word types, command codes and character constants of the gap buffer editor core
package gbte_pkg;

   localparam int OP_W    = 4;
   localparam int CH_W    = 8;
   localparam int CNT_W   = 12;
   localparam int CUR_W   = 12;
   localparam int ROW_W   = 13;

   localparam logic [OP_W-1:0] OP_INSERT    = 4'd0;
   localparam logic [OP_W-1:0] OP_DELETE    = 4'd1;
   localparam logic [OP_W-1:0] OP_BKSP      = 4'd2;
   localparam logic [OP_W-1:0] OP_LEFT      = 4'd3;
   localparam logic [OP_W-1:0] OP_RIGHT     = 4'd4;
   localparam logic [OP_W-1:0] OP_BUFSTART  = 4'd5;
   localparam logic [OP_W-1:0] OP_BUFEND    = 4'd6;
   localparam logic [OP_W-1:0] OP_LINESTART = 4'd7;
   localparam logic [OP_W-1:0] OP_LINEEND   = 4'd8;
   localparam logic [OP_W-1:0] OP_SETMARK   = 4'd9;
   localparam logic [OP_W-1:0] OP_CLEARMARK = 4'd10;
   localparam logic [OP_W-1:0] OP_BRACKET   = 4'd11;

   localparam logic [CH_W-1:0] CH_NL     = 8'h0A;
   localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [CH_W-1:0] CH_LBRACE = 8'h7B;
   localparam logic [CH_W-1:0] CH_RBRACE = 8'h7D;
   localparam logic [CH_W-1:0] CH_LBRACK = 8'h5B;
   localparam logic [CH_W-1:0] CH_RBRACK = 8'h5D;
   localparam logic [CH_W-1:0] CH_LANGLE = 8'h3C;
   localparam logic [CH_W-1:0] CH_RANGLE = 8'h3E;
   localparam logic [CH_W-1:0] CH_NUL    = 8'h00;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [CH_W-1:0]  ch;
      logic [CNT_W-1:0] count;
   } req_type;

   typedef struct packed {
      logic             status;
      logic [CUR_W-1:0] cursor_pos;
      logic [ROW_W-1:0] row;
      logic [CH_W-1:0]  char_at_cursor;
      logic             modified;
      logic             mark_active;
   } rsp_type;

   typedef struct packed {
      logic             bad;
      logic [OP_W-1:0]  op;
      logic [CH_W-1:0]  ch;
      logic [CNT_W-1:0] count;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic gap_ok;
      logic end_ok;
   } bk_stat_type;

   typedef struct packed {
      logic            hit;
      logic            fwd;
      logic [CH_W-1:0] want;
   } br_type;

   function automatic br_type bracket_info(input logic [CH_W-1:0] c);
      br_type r;
      r.hit  = 1'b1;
      r.fwd  = 1'b1;
      r.want = CH_NUL;
      case (c)
         CH_LPAREN: r.want = CH_RPAREN;
         CH_LBRACE: r.want = CH_RBRACE;
         CH_LBRACK: r.want = CH_RBRACK;
         CH_LANGLE: r.want = CH_RANGLE;
         CH_RPAREN: begin r.want = CH_LPAREN; r.fwd = 1'b0; end
         CH_RBRACE: begin r.want = CH_LBRACE; r.fwd = 1'b0; end
         CH_RBRACK: begin r.want = CH_LBRACK; r.fwd = 1'b0; end
         CH_RANGLE: begin r.want = CH_LANGLE; r.fwd = 1'b0; end
         default:   r.hit = 1'b0;
      endcase
      return r;
   endfunction

endpackage

/* src/gbte_ram.sv */
// generic single write, single read ram with registered read data
module gbte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/gbte_front.sv */
// front end: command queue and op classification
module gbte_front import gbte_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_word,
   output logic    cmd_valid,
   input  logic    cmd_ready,
   output cmd_type cmd_word
);

   req_type     q_ff [2];
   logic        wp_ff, wp_in;
   logic        rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        put, take;
   req_type     head;

   assign req_full  = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign put       = req_push && !req_full;
   assign take      = cmd_valid && cmd_ready;
   assign head      = q_ff[rp_ff];

   always_comb begin
      cmd_word.bad   = (head.op > OP_BRACKET);
      cmd_word.op    = head.op;
      cmd_word.ch    = head.ch;
      cmd_word.count = head.count;
   end

   always_comb begin
      wp_in  = put  ? ~wp_ff : wp_ff;
      rp_in  = take ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, put} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (put) begin
         q_ff[wp_ff] <= req_word;
      end
   end

endmodule

/* src/gbte_back.sv */
// back end: gap buffer sequencer over the text ram and result queue
module gbte_back import gbte_pkg::*; #(
   parameter int BUF_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd_word,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_word,
   output bk_stat_type stat
);

   localparam int AW  = $clog2(BUF_BYTES);
   localparam int RW  = AW + 1;
   localparam int DW  = ((AW > CNT_W) ? AW : CNT_W) + 1;
   localparam logic [AW-1:0] END_CELL = AW'(BUF_BYTES - 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_BR_RD  = 4'd1;
   localparam logic [3:0] S_BR_EV  = 4'd2;
   localparam logic [3:0] S_SC_RD  = 4'd3;
   localparam logic [3:0] S_SC_EV  = 4'd4;
   localparam logic [3:0] S_MV_RD  = 4'd5;
   localparam logic [3:0] S_MV_EX  = 4'd6;
   localparam logic [3:0] S_INS    = 4'd7;
   localparam logic [3:0] S_FIN_RD = 4'd8;
   localparam logic [3:0] S_FIN_WR = 4'd9;

   logic [3:0]      state_ff, state_in;
   logic [AW-1:0]   gs_ff, gs_in;
   logic [AW-1:0]   ags_ff, ags_in;
   logic [RW-1:0]   row_ff, row_in;
   logic            mod_ff, mod_in;
   logic            mark_ff, mark_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic            dir_ff, dir_in;
   logic            nls_ff, nls_in;
   logic            bks_ff, bks_in;
   logic            status_ff, status_in;
   logic [CH_W-1:0] ch_ff, ch_in;
   logic [CH_W-1:0] here_ff, here_in;
   logic [CH_W-1:0] want_ff, want_in;
   logic            fwd_ff, fwd_in;
   logic [AW-1:0]   p_ff, p_in;
   logic [RW-1:0]   depth_ff, depth_in;

   rsp_type         q_ff [2];
   logic            qwp_ff, qrp_ff;
   logic [1:0]      qcnt_ff;

   logic            we;
   logic [AW-1:0]   wa, ra;
   logic [CH_W-1:0] wd, rd_data;
   logic            push, pop, take, nl;
   logic [RW-1:0]   dn;
   br_type          br;
   rsp_type         res;

   gbte_ram #(.WIDTH(CH_W), .DEPTH(BUF_BYTES)) u_text (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (wa),
      .wr_data (wd),
      .rd_addr (ra),
      .rd_data (rd_data)
   );

   assign cmd_ready = (state_ff == S_IDLE) && (qcnt_ff != 2'd2);
   assign take      = cmd_valid && cmd_ready;
   assign nl        = (rd_data == CH_NL);
   assign br        = bracket_info(rd_data);
   assign dn        = depth_ff + RW'(rd_data == here_ff) - RW'(rd_data == want_ff);

   always_comb begin
      state_in  = state_ff;
      gs_in     = gs_ff;
      ags_in    = ags_ff;
      row_in    = row_ff;
      mod_in    = mod_ff;
      mark_in   = mark_ff;
      rem_in    = rem_ff;
      dir_in    = dir_ff;
      nls_in    = nls_ff;
      bks_in    = bks_ff;
      status_in = status_ff;
      ch_in     = ch_ff;
      here_in   = here_ff;
      want_in   = want_ff;
      fwd_in    = fwd_ff;
      p_in      = p_ff;
      depth_in  = depth_ff;
      we        = 1'b0;
      wa        = gs_ff;
      wd        = ch_ff;
      ra        = ags_ff;
      push      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               status_in = 1'b0;
               ch_in     = cmd_word.ch;
               nls_in    = 1'b0;
               bks_in    = 1'b0;
               state_in  = S_FIN_RD;
               if (cmd_word.bad) begin
                  status_in = 1'b1;
               end else begin
                  unique case (cmd_word.op) inside
                     OP_INSERT: begin
                        if (DW'(cmd_word.count) > DW'(ags_ff - gs_ff)) begin
                           status_in = 1'b1;
                        end else begin
                           rem_in = DW'(cmd_word.count);
                           if (cmd_word.ch == CH_NL) begin
                              row_in = row_ff + RW'(cmd_word.count);
                           end
                           mark_in  = 1'b0;
                           mod_in   = 1'b1;
                           state_in = S_INS;
                        end
                     end
                     OP_DELETE: begin
                        if (DW'(cmd_word.count) > DW'(END_CELL - ags_ff)) begin
                           status_in = 1'b1;
                        end else begin
                           ags_in  = AW'(DW'(ags_ff) + DW'(cmd_word.count));
                           mark_in = 1'b0;
                           mod_in  = 1'b1;
                        end
                     end
                     OP_BKSP, OP_LEFT: begin
                        if (DW'(cmd_word.count) > DW'(gs_ff)) begin
                           status_in = 1'b1;
                        end else begin
                           rem_in   = DW'(cmd_word.count);
                           dir_in   = 1'b1;
                           state_in = S_MV_RD;
                           if (cmd_word.op == OP_BKSP) begin
                              bks_in  = 1'b1;
                              mark_in = 1'b0;
                              mod_in  = 1'b1;
                           end
                        end
                     end
                     OP_RIGHT: begin
                        if (DW'(cmd_word.count) > DW'(END_CELL - ags_ff)) begin
                           status_in = 1'b1;
                        end else begin
                           rem_in   = DW'(cmd_word.count);
                           dir_in   = 1'b0;
                           state_in = S_MV_RD;
                        end
                     end
                     OP_BUFSTART, OP_LINESTART: begin
                        rem_in   = DW'(gs_ff);
                        dir_in   = 1'b1;
                        nls_in   = (cmd_word.op == OP_LINESTART);
                        state_in = S_MV_RD;
                     end
                     OP_BUFEND, OP_LINEEND: begin
                        rem_in   = DW'(END_CELL - ags_ff);
                        dir_in   = 1'b0;
                        nls_in   = (cmd_word.op == OP_LINEEND);
                        state_in = S_MV_RD;
                     end
                     OP_SETMARK:   mark_in = 1'b1;
                     OP_CLEARMARK: mark_in = 1'b0;
                     OP_BRACKET:   state_in = S_BR_RD;
                     default:      status_in = 1'b1;
                  endcase
               end
            end
         end
         S_BR_RD: begin
            if (ags_ff == END_CELL) begin
               status_in = 1'b1;
               state_in  = S_FIN_RD;
            end else begin
               ra       = ags_ff;
               state_in = S_BR_EV;
            end
         end
         S_BR_EV: begin
            if (!br.hit) begin
               status_in = 1'b1;
               state_in  = S_FIN_RD;
            end else begin
               here_in  = rd_data;
               want_in  = br.want;
               fwd_in   = br.fwd;
               depth_in = RW'(1);
               p_in     = br.fwd ? ags_ff + 1'b1 : gs_ff;
               state_in = S_SC_RD;
            end
         end
         S_SC_RD: begin
            if (fwd_ff) begin
               if (p_ff == END_CELL) begin
                  status_in = 1'b1;
                  state_in  = S_FIN_RD;
               end else begin
                  ra       = p_ff;
                  state_in = S_SC_EV;
               end
            end else begin
               if (p_ff == '0) begin
                  status_in = 1'b1;
                  state_in  = S_FIN_RD;
               end else begin
                  ra       = p_ff - 1'b1;
                  p_in     = p_ff - 1'b1;
                  state_in = S_SC_EV;
               end
            end
         end
         S_SC_EV: begin
            if ((rd_data == want_ff) && (dn == '0)) begin
               rem_in   = fwd_ff ? DW'(p_ff - ags_ff) : DW'(gs_ff - p_ff);
               dir_in   = !fwd_ff;
               state_in = S_MV_RD;
            end else begin
               depth_in = dn;
               if (fwd_ff) begin
                  p_in = p_ff + 1'b1;
               end
               state_in = S_SC_RD;
            end
         end
         S_MV_RD: begin
            if (rem_ff == '0) begin
               state_in = S_FIN_RD;
            end else begin
               ra       = dir_ff ? gs_ff - 1'b1 : ags_ff;
               state_in = S_MV_EX;
            end
         end
         S_MV_EX: begin
            if (nls_ff && nl) begin
               state_in = S_FIN_RD;
            end else begin
               rem_in   = rem_ff - 1'b1;
               state_in = S_MV_RD;
               if (dir_ff) begin
                  gs_in  = gs_ff - 1'b1;
                  row_in = row_ff - RW'(nl);
                  if (!bks_ff) begin
                     we     = 1'b1;
                     wa     = ags_ff - 1'b1;
                     wd     = rd_data;
                     ags_in = ags_ff - 1'b1;
                  end
               end else begin
                  we     = 1'b1;
                  wa     = gs_ff;
                  wd     = rd_data;
                  gs_in  = gs_ff + 1'b1;
                  ags_in = ags_ff + 1'b1;
                  row_in = row_ff + RW'(nl);
               end
            end
         end
         S_INS: begin
            if (rem_ff == '0) begin
               state_in = S_FIN_RD;
            end else begin
               we     = 1'b1;
               wa     = gs_ff;
               wd     = ch_ff;
               gs_in  = gs_ff + 1'b1;
               rem_in = rem_ff - 1'b1;
            end
         end
         S_FIN_RD: begin
            ra       = ags_ff;
            state_in = S_FIN_WR;
         end
         S_FIN_WR: begin
            push     = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      res.status         = status_ff;
      res.cursor_pos     = CUR_W'(gs_ff);
      res.row            = ROW_W'(row_ff);
      res.char_at_cursor = (ags_ff == END_CELL) ? CH_NUL : rd_data;
      res.modified       = mod_ff;
      res.mark_active    = mark_ff;
   end

   assign rsp_empty = (qcnt_ff == 2'd0);
   assign pop       = rsp_pop && !rsp_empty;
   assign rsp_word  = q_ff[qrp_ff];

   assign stat.busy   = (state_ff != S_IDLE);
   assign stat.gap_ok = (gs_ff <= ags_ff);
   assign stat.end_ok = (ags_ff <= END_CELL);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         gs_ff    <= '0;
         ags_ff   <= END_CELL;
         row_ff   <= RW'(1);
         mod_ff   <= 1'b0;
         mark_ff  <= 1'b0;
         qwp_ff   <= 1'b0;
         qrp_ff   <= 1'b0;
         qcnt_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         gs_ff    <= gs_in;
         ags_ff   <= ags_in;
         row_ff   <= row_in;
         mod_ff   <= mod_in;
         mark_ff  <= mark_in;
         qwp_ff   <= push ? ~qwp_ff : qwp_ff;
         qrp_ff   <= pop ? ~qrp_ff : qrp_ff;
         qcnt_ff  <= qcnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      dir_ff    <= dir_in;
      nls_ff    <= nls_in;
      bks_ff    <= bks_in;
      status_ff <= status_in;
      ch_ff     <= ch_in;
      here_ff   <= here_in;
      want_ff   <= want_in;
      fwd_ff    <= fwd_in;
      p_ff      <= p_in;
      depth_ff  <= depth_in;
      if (push) begin
         q_ff[qwp_ff] <= res;
      end
   end

endmodule

/* src/gap_buffer_text_editor_core.sv */
// top level: gap buffer text editor core
// Edit commands enter through a two word queue and results leave through a two word
// queue, so either side may stall. Commands run one at a time through the single text
// ram: each byte that crosses the gap, is scanned for a bracket match or is passed by
// backspace is first read and then written or counted, inserted bytes are written
// without a read, and each command ends by reading the cursor byte and pushing its
// result. A bracket jump may scan and then move up to BUF_BYTES bytes. No clearing pass.
module gap_buffer_text_editor_core import gbte_pkg::*; #(
   parameter int BUF_BYTES = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_word,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_word
);

   logic        cmd_valid;
   logic        cmd_ready;
   cmd_type     cmd_word;
   bk_stat_type stat;

   gbte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_word  (cmd_word)
   );

   gbte_back #(.BUF_BYTES(BUF_BYTES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_word  (cmd_word),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word),
      .stat      (stat)
   );

   a_gap_order: assert property (@(posedge clock) disable iff (reset) stat.gap_ok)
      else $error("gap start passed gap end");

   a_gap_end: assert property (@(posedge clock) disable iff (reset) stat.end_ok)
      else $error("gap end beyond end cell");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && cmd_ready) |=> stat.busy)
      else $error("command taken but back end stayed idle");

   a_busy_hold: assert property (@(posedge clock) disable iff (reset)
      stat.busy |-> !cmd_ready)
      else $error("back end took a command while busy");

endmodule
